/* hdl/scft_pkg.sv */
// Package for the second-chance frame table: field widths, codes and the
// request, response and frame record types. No dependencies.
package scft_pkg;

  // Fixed widths of the transfer fields.
  localparam int ACTION_W = 2;
  localparam int FRAME_W  = 6;
  localparam int TAG_W    = 20;
  localparam int OWNER_W  = 6;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;

  // Defaults for the top-level parameters.
  localparam int DEF_NUM_FRAMES = 64;
  localparam int DEF_TAG_BITS   = 20;

  // Request actions.
  localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REF   = 2'd2;

  // Backing kinds that the eviction logic recognizes.
  localparam logic [KIND_W-1:0] KIND_SWAP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FILE = 2'd2;

  // Response status codes.
  localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_FRAME    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN_KIND = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [FRAME_W-1:0]  frame_index;
    logic [TAG_W-1:0]    page_tag;
    logic [OWNER_W-1:0]  owner_id;
    logic [KIND_W-1:0]   page_kind;
    logic                is_write;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  granted_frame;
    logic                evicted;
    logic [TAG_W-1:0]    victim_tag;
    logic [OWNER_W-1:0]  victim_owner;
    logic                swap_out;
  } rsp_t;

  // Per-frame bookkeeping kept beside the tag.
  typedef struct packed {
    logic               valid;
    logic               accessed;
    logic               dirty;
    logic [KIND_W-1:0]  kind;
    logic [OWNER_W-1:0] owner;
  } frame_flags_t;

  // Write enables into the frame store.
  typedef struct packed {
    logic flags_we;
    logic tag_we;
  } frame_wr_t;

endpackage

/* hdl/scft_frame_store.sv */
// Frame store: per-frame flags memory and tag memory with registered reads,
// plus the clearing pass over the flags after reset. Depends on scft_pkg.
module scft_frame_store import scft_pkg::*; #(
  parameter int NUM_FRAMES = DEF_NUM_FRAMES,
  parameter int TAG_BITS   = DEF_TAG_BITS,
  localparam int FB        = $clog2(NUM_FRAMES)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [FB-1:0]       raddr,
  output frame_flags_t        rflags,
  output logic [TAG_BITS-1:0] rtag,
  input  frame_wr_t           wr,
  input  logic [FB-1:0]       waddr,
  input  frame_flags_t        wflags,
  input  logic [TAG_BITS-1:0] wtag,
  output logic                busy
);

  frame_flags_t        flags_mem [NUM_FRAMES];
  logic [TAG_BITS-1:0] tag_mem   [NUM_FRAMES];
  logic [FB-1:0]       clr_addr;

  // Clearing pass: one flags entry per cycle after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == FB'(NUM_FRAMES - 1)) begin
        busy <= 1'b0;
      end
      clr_addr <= clr_addr + FB'(1);
    end
  end

  // Flags memory: the clearing pass owns the write port while it runs.
  always_ff @(posedge clk) begin
    if (busy) begin
      flags_mem[clr_addr] <= '0;
    end else if (wr.flags_we) begin
      flags_mem[waddr] <= wflags;
    end
    rflags <= flags_mem[raddr];
  end

  // Tag memory, written only when a page is installed.
  always_ff @(posedge clk) begin
    if (wr.tag_we) begin
      tag_mem[waddr] <= wtag;
    end
    rtag <= tag_mem[raddr];
  end

endmodule

/* hdl/second_chance_frame_table.sv */
// Second-chance frame table top level: request/response channels, the
// sequencer, and the install-order list. Depends on scft_pkg, scft_frame_store.
//
// The table holds NUM_FRAMES frames and serves one request at a time; req_ready
// is low while a request is in progress and after reset while the flags memory
// is cleared. Each memory has one read port. Allocate with a free frame steps
// over valid frames from a lowest-free hint (normally none); free searches the
// install-order list for the frame and closes the gap behind it; allocate with
// a full table moves the hand over the list (at most NUM_FRAMES + 1 frames
// visited, since the first pass clears every accessed bit), then closes the
// gap behind the victim; a dirty victim of unknown kind ends the request when
// the hand reaches it.
// A finished response waits in an output register, so the next request is
// taken while it is still pending.
module second_chance_frame_table import scft_pkg::*; #(
  parameter int NUM_FRAMES = DEF_NUM_FRAMES,
  parameter int TAG_BITS   = DEF_TAG_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int FB  = $clog2(NUM_FRAMES);
  localparam int CB  = $clog2(NUM_FRAMES + 1);
  localparam int IXB = (FB > FRAME_W) ? FB : FRAME_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_FREE_CHK,
    S_CHK,
    S_FIND,
    S_SHIFT,
    S_CLK_ORD,
    S_CLK_FRM,
    S_CLK_CHK,
    S_TAIL,
    S_RESULT
  } state_t;

  state_t        state;
  req_t          req_q;
  rsp_t          res;
  rsp_t          res_init;
  logic [CB-1:0] count;
  logic [CB-1:0] hint;
  logic [FB-1:0] cur;
  logic [FB-1:0] pos;

  // Install-order list memory.
  logic [FB-1:0] order_mem [NUM_FRAMES];
  logic [FB-1:0] om_q;
  logic [FB-1:0] om_raddr;
  logic [FB-1:0] om_waddr;
  logic [FB-1:0] om_wdata;
  logic          om_we;

  // Frame store ports.
  logic [FB-1:0]       fs_raddr;
  frame_flags_t        fs_rflags;
  logic [TAG_BITS-1:0] fs_rtag;
  frame_wr_t           fs_wr;
  frame_flags_t        fs_wflags;
  frame_flags_t        new_flags;
  logic                fs_busy;

  logic            req_xfer;
  logic            idx_bad;
  logic [FB-1:0]   idx_f;
  logic [FB-1:0]   pos_inc;
  logic            pos_last;
  logic [CB:0]     pos_p2;
  logic            pos_next_last;
  logic            unknown_kind;

  scft_frame_store #(
    .NUM_FRAMES(NUM_FRAMES),
    .TAG_BITS  (TAG_BITS)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .raddr (fs_raddr),
    .rflags(fs_rflags),
    .rtag  (fs_rtag),
    .wr    (fs_wr),
    .waddr (cur),
    .wflags(fs_wflags),
    .wtag  (TAG_BITS'(req_q.page_tag)),
    .busy  (fs_busy)
  );

  // Shared decode of the request and list position.
  assign req_ready     = (state == S_IDLE) && !fs_busy;
  assign req_xfer      = req_valid && req_ready;
  assign idx_bad       = (IXB + 1)'(req.frame_index) >= (IXB + 1)'(NUM_FRAMES);
  assign idx_f         = FB'(req.frame_index);
  assign pos_inc       = pos + FB'(1);
  assign pos_last      = (CB'(pos) + CB'(1)) == count;
  assign pos_p2        = (CB + 1)'(pos) + (CB + 1)'(2);
  assign pos_next_last = pos_p2 == (CB + 1)'(count);
  assign unknown_kind  = fs_rflags.dirty && (fs_rflags.kind != KIND_SWAP) &&
                         (fs_rflags.kind != KIND_FILE);

  // Starting response of an accepted request; an out-of-range frame index
  // is answered at once.
  always_comb begin
    res_init = '0;
    if ((req.action == ACT_FREE || req.action == ACT_REF) && idx_bad) begin
      res_init.status = ST_BAD_FRAME;
    end
  end

  // Record of a freshly installed page.
  always_comb begin
    new_flags          = '0;
    new_flags.valid    = 1'b1;
    new_flags.kind     = req_q.page_kind;
    new_flags.owner    = req_q.owner_id;
  end

  // Memory port control for each sequencer step.
  always_comb begin
    fs_raddr  = cur;
    fs_wr     = '0;
    fs_wflags = fs_rflags;
    om_raddr  = pos;
    om_we     = 1'b0;
    om_waddr  = pos;
    om_wdata  = cur;
    unique case (state)
      S_FREE_CHK: begin
        if (!fs_rflags.valid) begin
          fs_wr.flags_we = 1'b1;
          fs_wr.tag_we   = 1'b1;
          fs_wflags      = new_flags;
          om_we          = 1'b1;
          om_waddr       = FB'(count);
        end else begin
          fs_raddr = cur + FB'(1);
        end
      end
      S_CHK: begin
        om_raddr = '0;
        if (fs_rflags.valid) begin
          fs_wr.flags_we = 1'b1;
          if (req_q.action == ACT_REF) begin
            fs_wflags.accessed = 1'b1;
            fs_wflags.dirty    = fs_rflags.dirty | req_q.is_write;
          end else begin
            fs_wflags.valid    = 1'b0;
            fs_wflags.accessed = 1'b0;
            fs_wflags.dirty    = 1'b0;
          end
        end
      end
      S_FIND: begin
        om_raddr = pos_inc;
      end
      S_SHIFT: begin
        om_we    = 1'b1;
        om_wdata = om_q;
        om_raddr = FB'(pos_p2);
      end
      S_CLK_FRM: begin
        fs_raddr = om_q;
      end
      S_CLK_CHK: begin
        om_raddr = pos_inc;
        if (fs_rflags.accessed) begin
          fs_wr.flags_we     = 1'b1;
          fs_wflags.accessed = 1'b0;
        end else if (!unknown_kind) begin
          fs_wr.flags_we = 1'b1;
          fs_wr.tag_we   = 1'b1;
          fs_wflags      = new_flags;
        end
      end
      S_TAIL: begin
        om_we    = 1'b1;
        om_waddr = FB'(count - CB'(1));
      end
      default: begin
      end
    endcase
  end

  // Install-order list memory with registered read.
  always_ff @(posedge clk) begin
    if (om_we) begin
      order_mem[om_waddr] <= om_wdata;
    end
    om_q <= order_mem[om_raddr];
  end

  // Sequencer, list bookkeeping and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      hint      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // A taken response empties the output register unless a new one
      // is loaded in the same cycle.
      if (rsp_valid && rsp_ready && (state != S_RESULT)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_xfer) begin
            req_q <= req;
            res   <= res_init;
            unique case (req.action)
              ACT_ALLOC: begin
                if (count != CB'(NUM_FRAMES)) begin
                  cur   <= FB'(hint);
                  state <= S_FETCH;
                end else begin
                  pos   <= '0;
                  state <= S_CLK_ORD;
                end
              end
              ACT_FREE, ACT_REF: begin
                if (idx_bad) begin
                  state <= S_RESULT;
                end else begin
                  cur   <= idx_f;
                  state <= S_FETCH;
                end
              end
              default: begin
                state <= S_RESULT;
              end
            endcase
          end
        end
        S_FETCH: begin
          state <= (req_q.action == ACT_ALLOC) ? S_FREE_CHK : S_CHK;
        end
        // Walk up from the hint until a free frame turns up.
        S_FREE_CHK: begin
          if (!fs_rflags.valid) begin
            count             <= count + CB'(1);
            hint              <= CB'(cur) + CB'(1);
            res.granted_frame <= FRAME_W'(cur);
            state             <= S_RESULT;
          end else begin
            cur <= cur + FB'(1);
          end
        end
        S_CHK: begin
          if (!fs_rflags.valid) begin
            res.status <= ST_BAD_FRAME;
            state      <= S_RESULT;
          end else if (req_q.action == ACT_REF) begin
            state <= S_RESULT;
          end else begin
            if (CB'(cur) < hint) begin
              hint <= CB'(cur);
            end
            pos   <= '0;
            state <= S_FIND;
          end
        end
        // Search the list for the freed frame.
        S_FIND: begin
          if (om_q == cur) begin
            if (pos_last) begin
              count <= count - CB'(1);
              state <= S_RESULT;
            end else begin
              state <= S_SHIFT;
            end
          end else begin
            pos <= pos_inc;
          end
        end
        // Close the gap one entry per cycle.
        S_SHIFT: begin
          if (pos_next_last) begin
            if (req_q.action == ACT_ALLOC) begin
              state <= S_TAIL;
            end else begin
              count <= count - CB'(1);
              state <= S_RESULT;
            end
          end else begin
            pos <= pos_inc;
          end
        end
        S_CLK_ORD: begin
          state <= S_CLK_FRM;
        end
        S_CLK_FRM: begin
          cur   <= om_q;
          state <= S_CLK_CHK;
        end
        // The hand: skip and clear accessed frames, evict the first other unless it is a dirty frame of unknown kind.
        S_CLK_CHK: begin
          if (fs_rflags.accessed) begin
            pos   <= pos_last ? '0 : pos_inc;
            state <= S_CLK_ORD;
          end else begin
            res.victim_tag   <= TAG_W'(fs_rtag);
            res.victim_owner <= fs_rflags.owner;
            if (unknown_kind) begin
              res.status <= ST_UNKNOWN_KIND;
              state      <= S_RESULT;
            end else begin
              res.swap_out      <= fs_rflags.kind == KIND_SWAP;
              res.evicted       <= 1'b1;
              res.granted_frame <= FRAME_W'(cur);
              state             <= pos_last ? S_TAIL : S_SHIFT;
            end
          end
        end
        S_TAIL: begin
          state <= S_RESULT;
        end
        // Hand the result to the output register once it has room.
        S_RESULT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
